@@ design/serial_frame_deframer_xor_check_unit_macros.svh @@
// Assertion macros for the deframer modules; sfdxc_ctrl uses them.
`ifndef SERIAL_FRAME_DEFRAMER_XOR_CHECK_UNIT_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_XOR_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SFDXC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sfdxc assertion failed");
// Expression must never be true outside reset.
`define SFDXC_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("sfdxc forbidden condition seen");
`else
`define SFDXC_ASSERT(label, clk, rstn, prop)
`define SFDXC_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

@@ design/sfdxc_pkg.sv @@
package sfdxc_pkg;

    localparam int SFDXC_FRAME_BYTES = 66;
    localparam int WORD_FIELDS       = 27;
    localparam int BYTE_FIELDS       = 6;
    localparam int FIELD_COUNT       = WORD_FIELDS + BYTE_FIELDS;
    localparam int FIELD_W           = 6;
    localparam int CFG_INDEX_W       = 2;
    // Payload words start at frame byte 4, stored as byte pairs.
    localparam int WORD_BASE_ADDR    = 2;
    localparam int BYTE_BASE_ADDR    = WORD_BASE_ADDR + WORD_FIELDS;

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] ID_RESET     = 8'h20;
    localparam logic [7:0] FOOTER_RESET = 8'h55;

    typedef enum logic [1:0] {
        STATUS_FIELD   = 2'd0,
        STATUS_SUM_ERR = 2'd1,
        STATUS_LOST    = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER = 2'd0,
        REG_ID     = 2'd1,
        REG_FOOTER = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic take;     // accept the byte on s_rx_byte
        logic fetch;    // read the word of the current field
        logic fld_adv;  // current field was delivered
    } sfdxc_cmd_t;

    typedef struct packed {
        logic frame_end;   // the byte at hand closes a frame
        logic lost;        // framing check fails for that byte
        logic sum_bad;     // checksum differs
        logic fld_last;    // current field is the final one
        logic next_fetch;  // the next field needs a new word read
    } sfdxc_sts_t;

endpackage

@@ design/sfdxc_ram.sv @@
module sfdxc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sfdxc_dpath.sv @@
module sfdxc_dpath
    import sfdxc_pkg::*;
#(
    parameter int FRAME_BYTES = SFDXC_FRAME_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata,
    input  logic [7:0]             rx_byte,
    input  sfdxc_cmd_t             cmd,
    output sfdxc_sts_t             sts,
    output logic [1:0]             status,
    output logic [FIELD_W-1:0]     field_index,
    output logic signed [15:0]     field_value,
    output logic [7:0]             frame_counter,
    output logic                   last
);

    localparam int PW    = $clog2(FRAME_BYTES);
    localparam int DEPTH = (FRAME_BYTES + 1) / 2;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]         header_reg, id_reg, footer_reg;
    logic               locked_reg, saw_reg;
    logic [PW-1:0]      pos_reg;
    logic [7:0]         xor_reg;
    logic [7:0]         byte0_reg, byte1_reg, byte2_reg, chk_reg, lo_reg;
    status_t            status_reg;
    logic [FIELD_W-1:0] fld_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [15:0]        ram_rdata;
    logic [FIELD_W-1:0] boff, fld_inc, boff_inc;
    logic               is_word;
    logic [15:0]        value;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            id_reg     <= ID_RESET;
            footer_reg <= FOOTER_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEADER: header_reg <= cfg_wdata;
                REG_ID:     id_reg     <= cfg_wdata;
                REG_FOOTER: footer_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign sts.frame_end = locked_reg && (pos_reg == PW'(FRAME_BYTES - 1));
    assign sts.lost      = (byte0_reg != header_reg) || (byte1_reg != id_reg) ||
                           (rx_byte != footer_reg);
    assign sts.sum_bad   = (xor_reg != chk_reg);

    // Framer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg <= 1'b0;
            saw_reg    <= 1'b0;
            pos_reg    <= '0;
            xor_reg    <= '0;
            fld_reg    <= '0;
        end else begin
            if (cmd.take) begin
                if (!locked_reg) begin
                    if (saw_reg && rx_byte == id_reg) begin
                        locked_reg <= 1'b1;
                        saw_reg    <= 1'b0;
                        xor_reg    <= header_reg ^ rx_byte;
                        pos_reg    <= PW'(2);
                    end else begin
                        saw_reg <= (rx_byte == header_reg);
                    end
                end else if (sts.frame_end) begin
                    pos_reg <= '0;
                    xor_reg <= '0;
                    fld_reg <= '0;
                    if (sts.lost) begin
                        locked_reg <= 1'b0;
                        saw_reg    <= 1'b0;
                    end
                end else begin
                    pos_reg <= pos_reg + PW'(1);
                    if (pos_reg < PW'(FRAME_BYTES - 2)) begin
                        xor_reg <= xor_reg ^ rx_byte;
                    end
                end
            end
            if (cmd.fld_adv) begin
                fld_reg <= fld_inc;
            end
        end
    end

    // Frame bytes kept outside the RAM, and the result kind
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            if (!locked_reg) begin
                byte0_reg <= header_reg;
                byte1_reg <= rx_byte;
            end else begin
                if (pos_reg == PW'(0)) byte0_reg <= rx_byte;
                if (pos_reg == PW'(1)) byte1_reg <= rx_byte;
                if (pos_reg == PW'(2)) byte2_reg <= rx_byte;
                if (pos_reg == PW'(FRAME_BYTES - 2)) chk_reg <= rx_byte;
                if (!pos_reg[0]) lo_reg <= rx_byte;
                if (sts.frame_end) begin
                    status_reg <= sts.lost ? STATUS_LOST :
                                  (sts.sum_bad ? STATUS_SUM_ERR : STATUS_FIELD);
                end
            end
        end
    end

    // Odd byte completes a pair: store it as one word
    assign ram_we    = cmd.take && locked_reg && pos_reg[0];
    assign ram_waddr = AW'(pos_reg[PW-1:1]);

    assign is_word   = (fld_reg < FIELD_W'(WORD_FIELDS));
    assign boff      = fld_reg - FIELD_W'(WORD_FIELDS);
    assign fld_inc   = fld_reg + FIELD_W'(1);
    assign boff_inc  = fld_inc - FIELD_W'(WORD_FIELDS);
    assign ram_raddr = is_word ? AW'(WORD_BASE_ADDR) + AW'(fld_reg)
                               : AW'(BYTE_BASE_ADDR) + AW'(boff[FIELD_W-1:1]);

    assign sts.fld_last   = (fld_reg == FIELD_W'(FIELD_COUNT - 1));
    assign sts.next_fetch = (fld_inc < FIELD_W'(WORD_FIELDS)) || !boff_inc[0];

    sfdxc_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({rx_byte, lo_reg}),
        .re    (cmd.fetch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (status_reg != STATUS_FIELD) begin
            value = '0;
        end else if (is_word) begin
            value = ram_rdata;
        end else if (boff[0]) begin
            value = {8'h00, ram_rdata[15:8]};
        end else begin
            value = {8'h00, ram_rdata[7:0]};
        end
    end

    assign status        = status_reg;
    assign field_index   = (status_reg == STATUS_FIELD) ? fld_reg : '0;
    assign field_value   = $signed(value);
    assign frame_counter = byte2_reg;
    assign last          = (status_reg != STATUS_FIELD) || sts.fld_last;

endmodule

@@ design/sfdxc_ctrl.sv @@
`include "serial_frame_deframer_xor_check_unit_macros.svh"

module sfdxc_ctrl
    import sfdxc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  sfdxc_sts_t sts,
    output sfdxc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_BYTE,
        ST_RESULT,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, m_valid_reg;
    logic   take;

    assign take = s_valid && s_ready_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_BYTE: begin
                if (take && sts.frame_end) begin
                    state_next = (sts.lost || sts.sum_bad) ? ST_RESULT : ST_FETCH;
                end
            end
            ST_RESULT: begin
                if (m_ready) state_next = ST_BYTE;
            end
            ST_FETCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (sts.fld_last) begin
                        state_next = ST_BYTE;
                    end else if (sts.next_fetch) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_BYTE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_BYTE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_BYTE);
            m_valid_reg <= (state_next == ST_RESULT) || (state_next == ST_EMIT);
        end
    end

    assign s_ready     = s_ready_reg;
    assign m_valid     = m_valid_reg;
    assign cmd.take    = take;
    assign cmd.fetch   = (state_reg == ST_FETCH);
    assign cmd.fld_adv = (state_reg == ST_EMIT) && m_ready;

    `SFDXC_ASSERT_NEVER(a_ready_valid_excl, aclk, aresetn, s_ready_reg && m_valid_reg)
    `SFDXC_ASSERT(a_fetch_then_show, aclk, aresetn, cmd.fetch |=> m_valid_reg)
    `SFDXC_ASSERT(a_last_releases, aclk, aresetn, (state_reg == ST_EMIT && m_ready && sts.fld_last) |=> s_ready_reg)
    `SFDXC_ASSERT(a_valid_matches_state, aclk, aresetn, m_valid_reg |-> (state_reg == ST_RESULT || state_reg == ST_EMIT))

endmodule

@@ design/serial_frame_deframer_xor_check_unit.sv @@
// Channel   Dir  Signals                                                    Beat
// s_        in   s_valid s_ready s_rx_byte                                  one received byte
// m_        out  m_valid m_ready m_status m_field_index m_field_value        one result
//                m_frame_counter m_last
// cfg_      in   cfg_we cfg_index cfg_wdata                                 register write
//
// A byte that causes no result does not stall the input. A good frame's closing byte is
// followed by 33 result beats: each word field needs its own RAM read (ST_FETCH)
// before it is shown (ST_EMIT), byte fields read one word per two beats, and any
// m_ready stall holds the beats. An error frame gives one status beat.
// The pace of the results is set by the single read port of the 33 x 16 frame RAM.
// Reset is synchronous; s_ready is registered and rises in the cycle after aresetn goes high.
// The frame RAM is not cleared. While results are shown, s_ready stays low.
module serial_frame_deframer_xor_check_unit
    import sfdxc_pkg::*;
#(
    parameter int FRAME_BYTES = SFDXC_FRAME_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // byte input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    // result output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic [FIELD_W-1:0]     m_field_index,
    output logic signed [15:0]     m_field_value,
    output logic [7:0]             m_frame_counter,
    output logic                   m_last,
    // register writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata
);

    sfdxc_cmd_t cmd;  // controller to datapath: take byte, fetch word, advance field
    sfdxc_sts_t sts;  // datapath to controller: frame end, check outcome, field position

    // Controller: hunt/gather in ST_BYTE, then drive the result beats.
    sfdxc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: header search, running XOR, frame store and field formatting.
    sfdxc_dpath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .rx_byte       (s_rx_byte),
        .cmd           (cmd),
        .sts           (sts),
        .status        (m_status),
        .field_index   (m_field_index),
        .field_value   (m_field_value),
        .frame_counter (m_frame_counter),
        .last          (m_last)
    );

endmodule
